@@ hw/rtl/mmm_pkg.sv @@
// shared types and constants of the matrix multiply unit
package mmm_pkg;

    localparam int ELEM_W     = 16;
    localparam int PROD_W     = 40;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_ROWS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_COLS = 2'd2;

    // control handed from the sequencer to each cell
    typedef struct packed {
        logic wr_en;
        logic mac_vld;
        logic mac_first;
        logic mac_last;
        logic shift;
    } cell_ctl_t;

endpackage

@@ hw/rtl/mmm_elem_if.sv @@
// input element channel
interface mmm_elem_if;
    logic                              valid;
    logic                              ready;
    logic signed [mmm_pkg::ELEM_W-1:0] element;

    modport source (output valid, output element, input ready);
    modport sink   (input valid, input element, output ready);
endinterface

@@ hw/rtl/mmm_prod_if.sv @@
// product entry channel
interface mmm_prod_if;
    logic                              valid;
    logic                              ready;
    logic signed [mmm_pkg::PROD_W-1:0] product_value;
    logic                              last;

    modport source (output valid, output product_value, output last, input ready);
    modport sink   (input valid, input product_value, input last, output ready);
endinterface

@@ hw/rtl/mmm_cfg_if.sv @@
// configuration write channel
interface mmm_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [mmm_pkg::CFG_IDX_W-1:0]       index;
    logic [mmm_pkg::CFG_DATA_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/matrix_matrix_multiply_unit.sv @@
// matrix multiply unit: sequencer, left matrix memory and a chain of column cells
//
// channels: elem_in takes one signed Q8.8 element per item, the left matrix
// row-major and then the right matrix row-major. prod_out gives the product
// entries row-major as signed Q24.16 in 40 bits, with last on the final one.
// cfg writes left_rows (index 0), inner_size (1) and right_cols (2); values
// are clamped to 1..MAX_DIM and a write to any of these three restarts the
// load. cfg is ready only while loading, and elem_in holds off while a cfg
// write is offered. loading takes one element per cycle while no cfg write
// is offered. after the item that completes the right matrix, each product
// row is computed by multiply-accumulate, one element of the left row per
// cycle broadcast to one cell per column, then shifted out through the cell
// chain, the left row read one element at a time through the single read
// port of the left matrix memory. elem_in is not ready while a product is
// computed or shifted out. a stalled receiver holds the chain: the entry at
// the head stays until taken.
// reset returns all dimensions to MAX_DIM and clears the load count; the
// stores are not cleared, every entry is written before it is read.
module matrix_matrix_multiply_unit #(
    parameter int MAX_DIM = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    mmm_elem_if.sink          elem_in,
    mmm_prod_if.source        prod_out,
    mmm_cfg_if.sink           cfg
);

    localparam int DIM_W       = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int CNT_W       = $clog2(MAX_DIM + 1);
    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int LC_W        = $clog2(2 * STORE_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_MAC,
        ST_WAIT,
        ST_DRAIN
    } state_t;

    state_t                      state_reg;
    logic [CNT_W-1:0]            rows_reg;
    logic [CNT_W-1:0]            inner_reg;
    logic [CNT_W-1:0]            cols_reg;
    logic [LC_W-1:0]             load_count_reg;
    logic [DIM_W-1:0]            right_k_reg;
    logic [DIM_W-1:0]            right_j_reg;
    logic [ADDR_W-1:0]           rd_addr_reg;
    logic [DIM_W-1:0]            k_reg;
    logic [DIM_W-1:0]            row_reg;
    logic [CNT_W-1:0]            drain_cnt_reg;
    logic                        s1_vld_reg;
    logic                        s1_first_reg;
    logic                        s1_last_reg;
    logic [DIM_W-1:0]            s1_k_reg;
    logic                        s2_done_reg;
    logic [mmm_pkg::ELEM_W-1:0]  rd_data_reg;

    logic [mmm_pkg::ELEM_W-1:0]  left_mem [STORE_DEPTH];

    logic [LC_W-1:0]             left_total;
    logic [LC_W-1:0]             all_total;
    logic [CNT_W-1:0]            rows_m1;
    logic [CNT_W-1:0]            inner_m1;
    logic [CNT_W-1:0]            cols_m1;
    logic                        in_acc;
    logic                        out_acc;
    logic                        cfg_acc;
    logic                        is_left;
    logic                        right_wr;
    logic                        cfg_known;
    logic [CNT_W-1:0]            cfg_dim;
    logic                        last_entry;
    mmm_pkg::cell_ctl_t          cell_ctl [MAX_DIM];
    logic [mmm_pkg::PROD_W-1:0]  chain [MAX_DIM];

    assign left_total = LC_W'(rows_reg) * LC_W'(inner_reg);
    assign all_total  = left_total + LC_W'(inner_reg) * LC_W'(cols_reg);
    assign rows_m1    = rows_reg - CNT_W'(1);
    assign inner_m1   = inner_reg - CNT_W'(1);
    assign cols_m1    = cols_reg - CNT_W'(1);

    assign in_acc   = elem_in.valid && elem_in.ready;
    assign out_acc  = prod_out.valid && prod_out.ready;
    assign cfg_acc  = cfg.valid && cfg.ready;
    assign is_left  = load_count_reg < left_total;
    assign right_wr = in_acc && !is_left;

    assign cfg_known = (cfg.index == mmm_pkg::CFG_LEFT_ROWS) ||
                       (cfg.index == mmm_pkg::CFG_INNER_SIZE) ||
                       (cfg.index == mmm_pkg::CFG_RIGHT_COLS);

    // clamp a written dimension to 1..MAX_DIM
    always_comb
    begin
        if (cfg.data == '0)
        begin
            cfg_dim = CNT_W'(1);
        end
        else if (cfg.data > mmm_pkg::CFG_DATA_W'(MAX_DIM))
        begin
            cfg_dim = CNT_W'(MAX_DIM);
        end
        else
        begin
            cfg_dim = CNT_W'(cfg.data);
        end
    end

    assign last_entry = (row_reg == rows_m1[DIM_W-1:0]) && (drain_cnt_reg == CNT_W'(1));

    // a cfg write goes ahead of an element offered in the same cycle
    assign elem_in.ready          = (state_reg == ST_LOAD) && !cfg.valid;
    assign cfg.ready              = (state_reg == ST_LOAD);
    assign prod_out.valid         = (state_reg == ST_DRAIN);
    assign prod_out.product_value = chain[0];
    assign prod_out.last          = last_entry;

    always_comb
    begin
        for (int j = 0; j < MAX_DIM; j++)
        begin
            cell_ctl[j].wr_en     = right_wr && (right_j_reg == DIM_W'(j));
            cell_ctl[j].mac_vld   = s1_vld_reg;
            cell_ctl[j].mac_first = s1_first_reg;
            cell_ctl[j].mac_last  = s1_last_reg;
            cell_ctl[j].shift     = out_acc;
        end
    end

    // left matrix memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (in_acc && is_left)
        begin
            left_mem[load_count_reg[ADDR_W-1:0]] <= elem_in.element;
        end
        rd_data_reg <= left_mem[rd_addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_LOAD;
            rows_reg       <= CNT_W'(MAX_DIM);
            inner_reg      <= CNT_W'(MAX_DIM);
            cols_reg       <= CNT_W'(MAX_DIM);
            load_count_reg <= '0;
            right_k_reg    <= '0;
            right_j_reg    <= '0;
            rd_addr_reg    <= '0;
            k_reg          <= '0;
            row_reg        <= '0;
            drain_cnt_reg  <= '0;
            s1_vld_reg     <= 1'b0;
            s1_first_reg   <= 1'b0;
            s1_last_reg    <= 1'b0;
            s1_k_reg       <= '0;
            s2_done_reg    <= 1'b0;
        end
        else
        begin
            s1_vld_reg   <= (state_reg == ST_MAC);
            s1_first_reg <= (k_reg == '0);
            s1_last_reg  <= (k_reg == inner_m1[DIM_W-1:0]);
            s1_k_reg     <= k_reg;
            s2_done_reg  <= s1_vld_reg && s1_last_reg;

            case (state_reg)
                ST_LOAD:
                begin
                    if (in_acc)
                    begin
                        if (!is_left)
                        begin
                            if (right_j_reg == cols_m1[DIM_W-1:0])
                            begin
                                right_j_reg <= '0;
                                right_k_reg <= right_k_reg + DIM_W'(1);
                            end
                            else
                            begin
                                right_j_reg <= right_j_reg + DIM_W'(1);
                            end
                        end
                        if (load_count_reg + LC_W'(1) == all_total)
                        begin
                            load_count_reg <= '0;
                            right_j_reg    <= '0;
                            right_k_reg    <= '0;
                            rd_addr_reg    <= '0;
                            k_reg          <= '0;
                            row_reg        <= '0;
                            state_reg      <= ST_MAC;
                        end
                        else
                        begin
                            load_count_reg <= load_count_reg + LC_W'(1);
                        end
                    end
                end
                ST_MAC:
                begin
                    rd_addr_reg <= rd_addr_reg + ADDR_W'(1);
                    if (k_reg == inner_m1[DIM_W-1:0])
                    begin
                        k_reg     <= '0;
                        state_reg <= ST_WAIT;
                    end
                    else
                    begin
                        k_reg <= k_reg + DIM_W'(1);
                    end
                end
                ST_WAIT:
                begin
                    // cells capture the row sums at this edge
                    if (s2_done_reg)
                    begin
                        drain_cnt_reg <= cols_reg;
                        state_reg     <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    if (out_acc)
                    begin
                        drain_cnt_reg <= drain_cnt_reg - CNT_W'(1);
                        if (drain_cnt_reg == CNT_W'(1))
                        begin
                            if (row_reg == rows_m1[DIM_W-1:0])
                            begin
                                state_reg <= ST_LOAD;
                            end
                            else
                            begin
                                row_reg   <= row_reg + DIM_W'(1);
                                state_reg <= ST_MAC;
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase

            // a configuration write to a known index, taken only while loading, restarts the load
            if (cfg_acc && cfg_known)
            begin
                load_count_reg <= '0;
                right_j_reg    <= '0;
                right_k_reg    <= '0;
                if (cfg.index == mmm_pkg::CFG_LEFT_ROWS)
                begin
                    rows_reg <= cfg_dim;
                end
                else if (cfg.index == mmm_pkg::CFG_INNER_SIZE)
                begin
                    inner_reg <= cfg_dim;
                end
                else
                begin
                    cols_reg <= cfg_dim;
                end
            end
        end
    end

    for (genvar j = 0; j < MAX_DIM; j++)
    begin : g_cell
        logic [mmm_pkg::PROD_W-1:0] next_in;

        if (j + 1 < MAX_DIM)
        begin : g_mid
            assign next_in = chain[j+1];
        end
        else
        begin : g_end
            assign next_in = '0;
        end

        mmm_cell #(
            .MAX_DIM (MAX_DIM)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (cell_ctl[j]),
            .wr_row    (right_k_reg),
            .wr_data   (elem_in.element),
            .mac_k     (s1_k_reg),
            .mac_a     (rd_data_reg),
            .shift_in  (next_in),
            .shift_out (chain[j])
        );
    end

endmodule

@@ hw/rtl/mmm_cell.sv @@
// one column cell: right matrix column, multiply-accumulate and output shift stage
module mmm_cell #(
    parameter  int MAX_DIM = 8,
    localparam int DIM_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  mmm_pkg::cell_ctl_t                ctl,
    input  logic [DIM_W-1:0]                  wr_row,
    input  logic [mmm_pkg::ELEM_W-1:0]        wr_data,
    input  logic [DIM_W-1:0]                  mac_k,
    input  logic signed [mmm_pkg::ELEM_W-1:0] mac_a,
    input  logic [mmm_pkg::PROD_W-1:0]        shift_in,
    output logic [mmm_pkg::PROD_W-1:0]        shift_out
);

    localparam int MUL_W  = 2 * mmm_pkg::ELEM_W;
    localparam int EXT_W  = mmm_pkg::PROD_W - MUL_W;

    logic [mmm_pkg::ELEM_W-1:0]     col_store [MAX_DIM];
    logic signed [mmm_pkg::ELEM_W-1:0] col_rd;
    logic signed [MUL_W-1:0]        prod_next;
    logic signed [MUL_W-1:0]        prod_reg;
    logic                           p_vld_reg;
    logic                           p_first_reg;
    logic                           p_last_reg;
    logic [mmm_pkg::PROD_W-1:0]     prod_ext;
    logic [mmm_pkg::PROD_W-1:0]     acc_reg;
    logic [mmm_pkg::PROD_W-1:0]     acc_next;
    logic [mmm_pkg::PROD_W-1:0]     shift_reg;

    assign col_rd    = col_store[mac_k];
    assign prod_next = mac_a * col_rd;
    assign prod_ext  = {{EXT_W{prod_reg[MUL_W-1]}}, prod_reg};
    assign acc_next  = p_first_reg ? prod_ext : acc_reg + prod_ext;
    assign shift_out = shift_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            col_store[wr_row] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_vld_reg   <= 1'b0;
            p_first_reg <= 1'b0;
            p_last_reg  <= 1'b0;
        end
        else
        begin
            p_vld_reg   <= ctl.mac_vld;
            p_first_reg <= ctl.mac_first;
            p_last_reg  <= ctl.mac_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mac_vld)
        begin
            prod_reg <= prod_next;
        end
        if (p_vld_reg)
        begin
            acc_reg <= acc_next;
        end
        // row finished: capture the sum, otherwise move toward the output on a shift
        if (p_vld_reg && p_last_reg)
        begin
            shift_reg <= acc_next;
        end
        else if (ctl.shift)
        begin
            shift_reg <= shift_in;
        end
    end

endmodule
